@@ design/rct_pkg.sv @@
// ----------------------------------------------------------------------------
// rct_pkg
// Shared types and constants for the range coverage tracker: bitmap sizing,
// request codes and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rct_pkg;

    localparam int DOMAIN_SIZE = 1024;
    localparam int WORD_BITS   = 32;
    localparam int NWORDS      = (DOMAIN_SIZE + WORD_BITS - 1) / WORD_BITS;
    localparam int IDX_W       = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int BIT_W       = $clog2(WORD_BITS);
    localparam int POS_W       = 11;
    localparam int OP_W        = 2;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [BIT_W-1:0]     t_bit;
    typedef logic [POS_W-1:0]     t_pos;
    typedef logic [OP_W-1:0]      t_op;

    localparam t_op OP_ADD    = 2'd0;
    localparam t_op OP_REMOVE = 2'd1;
    localparam t_op OP_QUERY  = 2'd2;
    localparam t_op OP_NONE   = 2'd3;

    localparam t_pos POS_LIMIT = POS_W'(DOMAIN_SIZE);

    typedef struct packed {
        logic latch;     // capture a new request word
        logic init;      // point at first word, preset the coverage flag
        logic rd_en;     // read the current word and advance
        logic load_out;  // move the coverage flag into the output register
    } t_cmd;

    typedef struct packed {
        logic skip;      // empty range or unused code: no walk
        logic is_query;
        logic at_last;   // current word is the last of the range
        logic out_busy;  // output register holds an untaken word
    } t_sts;

endpackage

@@ design/range_coverage_tracker.sv @@
// ----------------------------------------------------------------------------
// range_coverage_tracker
// Tracks a set of points over a fixed domain as a bitmap; adds, removes or
// tests half-open ranges, one request at a time.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                 | word
//  --------+-----------+---------------------------+-------------------------------
//  request | in        | i_in_valid / o_in_ready   | i_op, i_range_start, i_range_end
//  answer  | out       | o_out_valid / i_out_ready | o_fully_covered
//
//  A request spanning N bitmap words passes from accept to the next accept
//  through capture, check, one word read per cycle, a drain step for the
//  last write-back, and a finish step. The single read-modify-write pass
//  over the bitmap store runs one word per cycle.
//  An empty range or an unused code skips the walk (an empty query still finishes).
//  Reset clears the per-word valid bits at once; no clearing pass is needed.
//  A query whose answer finds the output register still full holds in its
//  finish cycle until the waiting word is taken; add and remove never stall.
// ----------------------------------------------------------------------------
module range_coverage_tracker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_op,
    input  logic [10:0]          i_range_start,
    input  logic [10:0]          i_range_end,
    // answer channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_fully_covered
);

    // command and status bundles between the sequencer and the datapath
    rct_pkg::t_cmd cmd;
    rct_pkg::t_sts sts;

    // sequencer: owns request acceptance and the walk over spanned words
    rct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath: bitmap store, masks, coverage flag and the answer register
    rct_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op            (i_op),
        .i_range_start   (i_range_start),
        .i_range_end     (i_range_end),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_fully_covered (o_fully_covered),
        .i_cmd           (cmd),
        .o_sts           (sts)
    );

endmodule

@@ design/rct_ctrl.sv @@
// ----------------------------------------------------------------------------
// rct_ctrl
// Request sequencer: accept, check, walk the spanned words, drain the
// read-modify-write stage, then hand off the query answer.
// ----------------------------------------------------------------------------
module rct_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  rct_pkg::t_sts i_sts,
    output rct_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_in_ready     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.init = 1'b1;
                if (!i_sts.skip) begin
                    n_state = S_WALK;
                end else if (i_sts.is_query) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_WALK: begin
                o_cmd.rd_en = 1'b1;
                if (i_sts.at_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!i_sts.is_query) begin
                    n_state = S_IDLE;
                end else if (!i_sts.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ design/rct_dpath.sv @@
// ----------------------------------------------------------------------------
// rct_dpath
// Bitmap store with per-word valid bits, word index counter, mask builder,
// read-modify-write stage, coverage flag and the output register.
// ----------------------------------------------------------------------------
module rct_dpath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rct_pkg::t_op  i_op,
    input  rct_pkg::t_pos i_range_start,
    input  rct_pkg::t_pos i_range_end,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output logic          o_fully_covered,
    input  rct_pkg::t_cmd i_cmd,
    output rct_pkg::t_sts o_sts
);

    rct_pkg::t_word r_mem [rct_pkg::NWORDS];
    logic [rct_pkg::NWORDS-1:0] r_wvalid;

    rct_pkg::t_op   r_op;
    rct_pkg::t_pos  r_s;
    rct_pkg::t_pos  r_e;
    rct_pkg::t_idx  r_idx;
    rct_pkg::t_idx  r_s2_idx;
    logic           r_s2_vld;
    rct_pkg::t_word r_rd_data;
    logic           r_rd_vld;
    logic           r_all;
    logic           r_out_vld;
    logic           r_out_bit;

    rct_pkg::t_pos  s_clamp;
    rct_pkg::t_pos  e_clamp;
    rct_pkg::t_pos  e_m1;
    rct_pkg::t_idx  w_first;
    rct_pkg::t_idx  w_last;
    rct_pkg::t_bit  s_lo;
    rct_pkg::t_bit  e_lo;
    rct_pkg::t_word mask;
    rct_pkg::t_word cur;
    rct_pkg::t_word upd;

    // clamp ends to the domain on capture
    assign s_clamp = (i_range_start > rct_pkg::POS_LIMIT) ? rct_pkg::POS_LIMIT : i_range_start;
    assign e_clamp = (i_range_end > rct_pkg::POS_LIMIT) ? rct_pkg::POS_LIMIT : i_range_end;

    assign e_m1    = r_e - rct_pkg::POS_W'(1);
    assign w_first = rct_pkg::IDX_W'(r_s / rct_pkg::WORD_BITS);
    assign w_last  = rct_pkg::IDX_W'(e_m1 / rct_pkg::WORD_BITS);
    assign s_lo    = rct_pkg::BIT_W'(r_s % rct_pkg::WORD_BITS);
    assign e_lo    = rct_pkg::BIT_W'(e_m1 % rct_pkg::WORD_BITS);

    always_comb begin
        for (int b = 0; b < rct_pkg::WORD_BITS; b++) begin
            mask[b] = ((r_s2_idx != w_first) || (rct_pkg::BIT_W'(b) >= s_lo)) &&
                      ((r_s2_idx != w_last)  || (rct_pkg::BIT_W'(b) <= e_lo));
        end
    end

    // never-written words read as cleared
    assign cur = r_rd_vld ? r_rd_data : '0;
    assign upd = (r_op == rct_pkg::OP_ADD) ? (cur | mask) : (cur & ~mask);

    assign o_sts.skip     = (r_op == rct_pkg::OP_NONE) || (r_s >= r_e);
    assign o_sts.is_query = (r_op == rct_pkg::OP_QUERY);
    assign o_sts.at_last  = (r_idx == w_last);
    assign o_sts.out_busy = r_out_vld && !i_out_ready;

    assign o_out_valid     = r_out_vld;
    assign o_fully_covered = r_out_bit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op <= i_op;
            r_s  <= s_clamp;
            r_e  <= e_clamp;
        end
        if (i_cmd.init) begin
            r_idx <= w_first;
            r_all <= 1'b1;
        end else begin
            if (i_cmd.rd_en) begin
                r_idx <= r_idx + rct_pkg::IDX_W'(1);
            end
            if (r_s2_vld && (r_op == rct_pkg::OP_QUERY)) begin
                r_all <= r_all & ((cur & mask) == mask);
            end
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[r_idx];
            r_rd_vld  <= r_wvalid[r_idx];
            r_s2_idx  <= r_idx;
        end
        if (r_s2_vld && (r_op != rct_pkg::OP_QUERY)) begin
            r_mem[r_s2_idx] <= upd;
        end
        if (i_cmd.load_out) begin
            r_out_bit <= r_all;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvalid  <= '0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s2_vld <= i_cmd.rd_en;
            if (r_s2_vld && (r_op != rct_pkg::OP_QUERY)) begin
                r_wvalid[r_s2_idx] <= 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> !(r_out_vld && !i_out_ready))
        else $error("pending result word overwritten");

    a_read_feeds_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_en |=> (r_s2_vld && (r_s2_idx == $past(r_idx))))
        else $error("read did not reach modify stage");

    a_stage_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_vld |-> ((r_s2_idx >= w_first) && (r_s2_idx <= w_last)))
        else $error("modify stage outside spanned words");

    a_no_walk_on_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.latch |-> (!i_cmd.rd_en && !r_s2_vld))
        else $error("new request captured during a walk");

endmodule
